/* design/ptsj_pkg.sv */
// ----------------------------------------------------------------------------
// ptsj_pkg
// Shared types and constants for the pan/tilt stepper jog core.
// ----------------------------------------------------------------------------
package ptsj_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CoilW   = 8;
  localparam int unsigned BtnW    = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_STEP_TICKS     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TRAVEL_MAX     = 2'd2;

  localparam logic [TickW-1:0] STEP_TICKS_RST     = 16'd20;
  localparam logic [TickW-1:0] DEBOUNCE_TICKS_RST = 16'd20;
  localparam logic [PosW-1:0]  TRAVEL_MAX_RST     = 6'd50;
  localparam logic [PosW-1:0]  HOME_POS           = 6'd25;
  localparam logic [TickW-1:0] TICK_SAT           = 16'hFFFF;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef struct packed {
    logic [TickW-1:0] step_ticks;
    logic [TickW-1:0] debounce_ticks;
    logic [PosW-1:0]  travel_max;
  } cfg_t;

  typedef struct packed {
    logic [CoilW-1:0] coils;
    logic [PosW-1:0]  pan_position;
    logic [PosW-1:0]  tilt_position;
    logic             busy;
  } res_t;

  // winding driven for a given direction and phase of the wave sequence
  function automatic logic [CoilW-1:0] coil_for(input dir_t dir, input logic [1:0] ph);
    logic [2:0] idx;
    begin
      case (dir)
        DIR_RIGHT: idx = {1'b0, 2'd3 - ph};
        DIR_LEFT:  idx = {1'b0, ph};
        DIR_UP:    idx = {1'b1, 2'd3 - ph};
        default:   idx = {1'b1, ph};
      endcase
      coil_for = CoilW'(1) << idx;
    end
  endfunction

endpackage

/* design/ptsj_cfg.sv */
// ----------------------------------------------------------------------------
// ptsj_cfg
// Configuration register file: step time, debounce time and travel limit.
// ----------------------------------------------------------------------------
module ptsj_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptsj_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ptsj_pkg::TickW-1:0]     cfg_wdata,
  output ptsj_pkg::cfg_t                 cfg
);
  import ptsj_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_ticks     <= STEP_TICKS_RST;
      cfg_r.debounce_ticks <= DEBOUNCE_TICKS_RST;
      cfg_r.travel_max     <= TRAVEL_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_TICKS:     cfg_r.step_ticks     <= cfg_wdata;
        REG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_wdata;
        REG_TRAVEL_MAX:     cfg_r.travel_max     <= cfg_wdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/ptsj_ctrl.sv */
// ----------------------------------------------------------------------------
// ptsj_ctrl
// Jog control state and per-tick next-state logic: debounce, wave-drive
// phase sequencing, soft limits and position update.
// ----------------------------------------------------------------------------
module ptsj_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_en,
  input  logic [ptsj_pkg::BtnW-1:0]   btn_n,
  input  ptsj_pkg::cfg_t              cfg,
  output ptsj_pkg::res_t              res
);
  import ptsj_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DEBOUNCE = 2'd1,
    ST_STEP     = 2'd2
  } state_t;

  state_t           state_r, state_nxt;
  dir_t             dir_r, dir_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [TickW-1:0] tick_r, tick_nxt, tick_inc;
  logic [PosW-1:0]  pan_r, pan_nxt, tilt_r, tilt_nxt;
  logic [CoilW-1:0] coil_r, coil_nxt;
  logic             can_go;
  logic             found;
  dir_t             hit_dir;

  function automatic logic can_move(input logic [BtnW-1:0] b, input dir_t d,
                                    input logic [PosW-1:0] pan,
                                    input logic [PosW-1:0] tilt,
                                    input logic [PosW-1:0] lim);
    logic ok;
    begin
      case (d)
        DIR_RIGHT: ok = pan < lim;
        DIR_LEFT:  ok = pan != '0;
        DIR_UP:    ok = tilt < lim;
        default:   ok = tilt != '0;
      endcase
      can_move = ok && !b[d];
    end
  endfunction

  assign tick_inc = (tick_r == TICK_SAT) ? tick_r : tick_r + TickW'(1);

  // round-robin search starting at the current direction
  always_comb begin
    dir_t d;
    found   = 1'b0;
    hit_dir = DIR_RIGHT;
    for (int k = 3; k >= 0; k--) begin
      d = dir_t'(dir_r + 2'(k));
      if (!btn_n[d]) begin
        found   = 1'b1;
        hit_dir = d;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    pan_nxt   = pan_r;
    tilt_nxt  = tilt_r;
    coil_nxt  = coil_r;
    can_go    = 1'b0;
    unique case (state_r)
      ST_DEBOUNCE: begin
        tick_nxt = tick_inc;
        can_go   = can_move(btn_n, dir_r, pan_r, tilt_r, cfg.travel_max);
        if (tick_inc >= cfg.debounce_ticks) begin
          tick_nxt  = '0;
          phase_nxt = '0;
          if (can_go) begin
            state_nxt = ST_STEP;
            coil_nxt  = coil_for(dir_r, 2'd0);
          end else begin
            state_nxt = ST_IDLE;
            coil_nxt  = '0;
            dir_nxt   = dir_t'(dir_r + 2'd1);
          end
        end
      end
      ST_STEP: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg.step_ticks) begin
          tick_nxt = '0;
          if (phase_r != 2'd3) begin
            phase_nxt = phase_r + 2'd1;
            coil_nxt  = coil_for(dir_r, phase_r + 2'd1);
          end else begin
            case (dir_r)
              DIR_RIGHT: if (pan_r < cfg.travel_max) pan_nxt = pan_r + PosW'(1);
              DIR_LEFT:  if (pan_r != '0) pan_nxt = pan_r - PosW'(1);
              DIR_UP:    if (tilt_r < cfg.travel_max) tilt_nxt = tilt_r + PosW'(1);
              default:   if (tilt_r != '0) tilt_nxt = tilt_r - PosW'(1);
            endcase
            can_go    = can_move(btn_n, dir_r, pan_nxt, tilt_nxt, cfg.travel_max);
            phase_nxt = '0;
            if (can_go) begin
              coil_nxt = coil_for(dir_r, 2'd0);
            end else begin
              state_nxt = ST_IDLE;
              coil_nxt  = '0;
              dir_nxt   = dir_t'(dir_r + 2'd1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        coil_nxt  = '0;
        if (found) begin
          dir_nxt   = hit_dir;
          state_nxt = ST_DEBOUNCE;
          tick_nxt  = '0;
        end else begin
          dir_nxt = DIR_RIGHT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dir_r   <= DIR_RIGHT;
      phase_r <= '0;
      tick_r  <= '0;
      pan_r   <= HOME_POS;
      tilt_r  <= HOME_POS;
      coil_r  <= '0;
    end else if (tick_en) begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      pan_r   <= pan_nxt;
      tilt_r  <= tilt_nxt;
      coil_r  <= coil_nxt;
    end
  end

  always_comb begin
    res.coils         = coil_nxt;
    res.pan_position  = pan_nxt;
    res.tilt_position = tilt_nxt;
    res.busy          = (state_nxt == ST_DEBOUNCE) || (state_nxt == ST_STEP);
  end

endmodule

/* design/pan_tilt_stepper_jog_core.sv */
// ----------------------------------------------------------------------------
// pan_tilt_stepper_jog_core
// Jogs a pan and a tilt stepper from four active-low buttons, one input
// transaction per timer tick.
//
// Each input transaction carries the button levels for one tick. Every
// accepted tick produces exactly one output transaction with the coil drives,
// both positions and a busy flag, as they stand after that tick.
// The input is captured in an input register; once the output register is
// free, the control logic updates its state and loads the result register
// from it, and out_valid is raised with that result.
// Throughput is one tick per cycle: the input register refills in the same
// cycle its tick moves on, and while a result waits the input register still
// takes one more tick. Only when both are full does in_ready drop, until
// out_ready takes the pending result; no transaction is lost or repeated.
// Reset (synchronous, active low) loads step and debounce times of 20 ticks,
// a travel limit of 50, both positions at 25, coils off and idle control.
// Configuration writes take effect at once; the user must make them while idle, unchecked.
// ----------------------------------------------------------------------------
module pan_tilt_stepper_jog_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptsj_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ptsj_pkg::TickW-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ptsj_pkg::BtnW-1:0]      in_buttons_n,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ptsj_pkg::CoilW-1:0]     out_coils,
  output logic [ptsj_pkg::PosW-1:0]      out_pan_position,
  output logic [ptsj_pkg::PosW-1:0]      out_tilt_position,
  output logic                           out_busy_res
);
  import ptsj_pkg::*;

  cfg_t            cfg;
  res_t            res;
  res_t            out_r;
  logic            out_valid_r;
  logic            s1_valid_r;
  logic [BtnW-1:0] s1_btn_r;
  logic            adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  ptsj_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ptsj_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (adv),
    .btn_n   (s1_btn_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_btn_r <= in_buttons_n;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coils         = out_r.coils;
  assign out_pan_position  = out_r.pan_position;
  assign out_tilt_position = out_r.tilt_position;
  assign out_busy_res      = out_r.busy;

endmodule

/* test/pan_tilt_stepper_jog_core_tb.sv */
// ----------------------------------------------------------------------------
// pan_tilt_stepper_jog_core_tb
// Self-checking testbench for the pan/tilt stepper jog core. A directed table
// checks the reset state and each jog direction. Random phases follow, each
// under its own timing and travel setting: held jogs, short broken presses and
// button noise. Debounce and step times at their largest values are included.
// Every output transaction is compared field by field with a typed table value
// or an in-bench model of the debounce and wave-drive sequencer. Both handshakes
// idle at random in most phases; the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module pan_tilt_stepper_jog_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptsj_pkg::*;

  typedef enum logic [1:0] {
    CTL_IDLE     = 2'd0,
    CTL_DEBOUNCE = 2'd1,
    CTL_STEP     = 2'd2
  } jog_ctl_t;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic        retune;
    logic [3:0]  btn;
    logic [7:0]  reps;
    logic        typed;
    res_t        want;
  } jog_row_t;

  typedef struct packed {
    logic [15:0] step;
    logic [15:0] deb;
    logic [5:0]  trav;
    logic [31:0] ticks;
    logic        long_run;
    logic        gaps;
  } plan_t;

  localparam res_t HOME_IDLE  = '{8'h00, 6'd25, 6'd25, 1'b0};
  localparam res_t HOME_BUSY  = '{8'h00, 6'd25, 6'd25, 1'b1};
  localparam res_t HOME_COIL3 = '{8'h08, 6'd25, 6'd25, 1'b1};

  localparam jog_row_t JOG_ROWS [15] = '{
    '{1'b0, 4'hF, 8'd1, 1'b1, HOME_IDLE},
    '{1'b0, 4'hF, 8'd1, 1'b1, HOME_IDLE},
    '{1'b1, 4'hE, 8'd1, 1'b1, HOME_BUSY},
    '{1'b0, 4'hE, 8'd1, 1'b1, HOME_COIL3},
    '{1'b0, 4'hE, 8'd4, 1'b0, HOME_IDLE},
    '{1'b0, 4'hF, 8'd4, 1'b0, HOME_IDLE},
    '{1'b0, 4'hD, 8'd6, 1'b0, HOME_IDLE},
    '{1'b0, 4'hF, 8'd1, 1'b0, HOME_IDLE},
    '{1'b0, 4'hB, 8'd6, 1'b0, HOME_IDLE},
    '{1'b0, 4'hF, 8'd1, 1'b0, HOME_IDLE},
    '{1'b0, 4'h7, 8'd6, 1'b0, HOME_IDLE},
    '{1'b0, 4'hF, 8'd1, 1'b0, HOME_IDLE},
    '{1'b0, 4'h0, 8'd5, 1'b0, HOME_IDLE},
    '{1'b0, 4'hA, 8'd3, 1'b0, HOME_IDLE},
    '{1'b0, 4'hF, 8'd2, 1'b0, HOME_IDLE}
  };

  localparam plan_t PHASE_PLAN [8] = '{
    '{16'd1,     16'd0,     6'd63, 32'd180, 1'b0, 1'b1},
    '{16'd0,     16'd1,     6'd0,  32'd100, 1'b0, 1'b1},
    '{16'd2,     16'd3,     6'd30, 32'd180, 1'b0, 1'b1},
    '{16'd20,    16'd20,    6'd50, 32'd150, 1'b0, 1'b1},
    '{16'd1,     16'd65535, 6'd63, 32'd100, 1'b1, 1'b1},
    '{16'd65535, 16'd0,     6'd63, 32'd100, 1'b1, 1'b0},
    '{16'd1,     16'd2,     6'd1,  32'd100, 1'b0, 1'b1},
    '{16'd3,     16'd1,     6'd45, 32'd150, 1'b0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BtnW-1:0]    in_buttons_n = 4'hF;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CoilW-1:0]   out_coils;
  logic [PosW-1:0]    out_pan_position;
  logic [PosW-1:0]    out_tilt_position;
  logic               out_busy_res;

  // model state and settings
  jog_ctl_t    ctl;
  dir_t        p_dir;
  logic [2:0]  p_phase;
  logic [15:0] p_tick;
  logic [5:0]  p_pan;
  logic [5:0]  p_tilt;
  logic [7:0]  p_coil;
  logic [15:0] p_step;
  logic [15:0] p_deb;
  logic [5:0]  p_travel;

  res_t        pending_drive_q [$];
  bit          drive_gaps = 1'b1;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned bad_count = 0;
  int unsigned settings_done = 0;
  int unsigned pan_lo = 25, pan_hi = 25, tilt_lo = 25, tilt_hi = 25;

  pan_tilt_stepper_jog_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_buttons_n      (in_buttons_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_coils         (out_coils),
    .out_pan_position  (out_pan_position),
    .out_tilt_position (out_tilt_position),
    .out_busy_res      (out_busy_res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(80_000_000);
    $display("pan_tilt_stepper_jog_core_tb failed");
    $finish;
  end

  function automatic logic [7:0] wave_coil(input dir_t d, input logic [2:0] ph);
    case (d)
      DIR_RIGHT: wave_coil = 8'h08 >> ph;
      DIR_LEFT:  wave_coil = 8'h01 << ph;
      DIR_UP:    wave_coil = 8'h80 >> ph;
      default:   wave_coil = 8'h10 << ph;
    endcase
  endfunction

  function void engage_or_idle(input logic [3:0] b);
    logic ok;
    case (p_dir)
      DIR_RIGHT: ok = !b[0] && (p_pan < p_travel);
      DIR_LEFT:  ok = !b[1] && (p_pan != 6'd0);
      DIR_UP:    ok = !b[2] && (p_tilt < p_travel);
      default:   ok = !b[3] && (p_tilt != 6'd0);
    endcase
    p_tick  = '0;
    p_phase = '0;
    if (ok) begin
      ctl    = CTL_STEP;
      p_coil = wave_coil(p_dir, 3'd0);
    end else begin
      ctl    = CTL_IDLE;
      p_coil = '0;
      p_dir  = dir_t'(p_dir + 2'd1);
    end
  endfunction

  task automatic advance_jog(input logic [3:0] b, output res_t r);
    logic found;
    dir_t nd;
    dir_t cand;
    case (ctl)
      CTL_DEBOUNCE: begin
        if (p_tick != TICK_SAT) p_tick++;
        if (p_tick >= p_deb) engage_or_idle(b);
      end
      CTL_STEP: begin
        if (p_tick != TICK_SAT) p_tick++;
        if (p_tick >= p_step) begin
          p_tick = '0;
          if (p_phase < 3'd3) begin
            p_phase++;
            p_coil = wave_coil(p_dir, p_phase);
          end else begin
            case (p_dir)
              DIR_RIGHT: if (p_pan < p_travel) p_pan++;
              DIR_LEFT:  if (p_pan != 6'd0) p_pan--;
              DIR_UP:    if (p_tilt < p_travel) p_tilt++;
              default:   if (p_tilt != 6'd0) p_tilt--;
            endcase
            engage_or_idle(b);
          end
        end
      end
      default: begin
        ctl    = CTL_IDLE;
        p_coil = '0;
        found  = 1'b0;
        nd     = p_dir;
        for (int k = 0; k < 4; k++) begin
          cand = dir_t'(p_dir + 2'(k));
          if (!found && !b[cand]) begin
            found = 1'b1;
            nd    = cand;
          end
        end
        if (found) begin
          p_dir  = nd;
          ctl    = CTL_DEBOUNCE;
          p_tick = '0;
        end else begin
          p_dir = DIR_RIGHT;
        end
      end
    endcase
    r.coils         = p_coil;
    r.pan_position  = p_pan;
    r.tilt_position = p_tilt;
    r.busy          = (ctl == CTL_DEBOUNCE) || (ctl == CTL_STEP);
  endtask

  task automatic offer_tick(input logic [3:0] b, input logic typed, input res_t want);
    res_t r;
    if (drive_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_buttons_n <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_jog(b, r);
    pending_drive_q.push_back(typed ? want : r);
    ticks_sent++;
    if (p_pan < pan_lo) pan_lo = p_pan;
    if (p_pan > pan_hi) pan_hi = p_pan;
    if (p_tilt < tilt_lo) tilt_lo = p_tilt;
    if (p_tilt > tilt_hi) tilt_hi = p_tilt;
    @(negedge clk);
  endtask

  task automatic load_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] stp, input logic [15:0] deb,
                               input logic [5:0] trav);
    in_valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    load_reg(REG_STEP_TICKS, stp);
    load_reg(REG_DEBOUNCE_TICKS, deb);
    load_reg(REG_TRAVEL_MAX, {10'($urandom), trav});
    load_reg(REG_SPARE, 16'($urandom));
    cfg_we   <= 1'b0;
    p_step   = stp;
    p_deb    = deb;
    p_travel = trav;
    settings_done++;
  endtask

  // output side: random gaps plus one long hold-off
  initial begin
    int unsigned gap_left;
    int unsigned hold_left;
    bit          hold_done;
    gap_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 64;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (drive_gaps && $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_drive_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected transaction: coils %h pan %0d tilt %0d busy %b",
                   out_coils, out_pan_position, out_tilt_position, out_busy_res);
      end else begin
        want = pending_drive_q.pop_front();
        if (out_coils !== want.coils || out_pan_position !== want.pan_position ||
            out_tilt_position !== want.tilt_position || out_busy_res !== want.busy) begin
          bad_count++;
          if (bad_count <= 10)
            $display("mismatch at result %0d: want %h %0d %0d %b, got %h %0d %0d %b",
                     results_seen, want.coils, want.pan_position, want.tilt_position,
                     want.busy, out_coils, out_pan_position, out_tilt_position, out_busy_res);
        end
      end
    end
  end

  initial begin
    logic [3:0]  held;
    int unsigned start;
    int unsigned span;
    int unsigned nsteps;
    int unsigned eff_deb;
    int unsigned eff_step;
    int unsigned pick;
    plan_t       cur;

    ctl      = CTL_IDLE;
    p_dir    = DIR_RIGHT;
    p_phase  = '0;
    p_tick   = '0;
    p_pan    = HOME_POS;
    p_tilt   = HOME_POS;
    p_coil   = '0;
    p_step   = STEP_TICKS_RST;
    p_deb    = DEBOUNCE_TICKS_RST;
    p_travel = TRAVEL_MAX_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (JOG_ROWS[i]) begin
      if (JOG_ROWS[i].retune) apply_setting(16'd1, 16'd0, 6'd63);
      repeat (JOG_ROWS[i].reps) offer_tick(JOG_ROWS[i].btn, JOG_ROWS[i].typed, JOG_ROWS[i].want);
    end

    foreach (PHASE_PLAN[i]) begin
      cur = PHASE_PLAN[i];
      apply_setting(cur.step, cur.deb, cur.trav);
      drive_gaps = cur.gaps;
      eff_deb    = (p_deb == 0) ? 1 : p_deb;
      eff_step   = (p_step == 0) ? 1 : p_step;
      if (cur.long_run) begin
        held = (p_pan < p_travel) ? 4'hE : 4'hB;
        repeat (cur.ticks) offer_tick(held, 1'b0, '0);
        repeat (5) offer_tick(4'hF, 1'b0, '0);
      end else begin
        start = ticks_sent;
        while (ticks_sent - start < cur.ticks) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            held = ~(4'b0001 << $urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) held = held & 4'($urandom);
            if (eff_step > 4) nsteps = $urandom_range(0, 2);
            else if ($urandom_range(0, 7) == 0) nsteps = $urandom_range(10, 40);
            else nsteps = $urandom_range(0, 4);
            span = eff_deb + 1 + nsteps * 4 * eff_step + $urandom_range(0, 2);
            repeat (span) offer_tick(held, 1'b0, '0);
            repeat ($urandom_range(1, 4)) offer_tick(4'hF, 1'b0, '0);
          end else if (pick < 9) begin
            held = ~(4'b0001 << $urandom_range(0, 3));
            repeat ($urandom_range(1, eff_deb + 4 * eff_step)) offer_tick(held, 1'b0, '0);
            offer_tick(4'hF, 1'b0, '0);
          end else begin
            repeat ($urandom_range(1, 8)) offer_tick(4'($urandom), 1'b0, '0);
          end
        end
      end
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && pending_drive_q.size() != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_drive_q.size() != 0) begin
      bad_count++;
      $display("%0d expected transactions never arrived", pending_drive_q.size());
    end

    $display("%0d ticks driven under %0d register settings, %0d results checked, %0d errors",
             ticks_sent, settings_done, results_seen, bad_count);
    $display("pan travelled %0d..%0d, tilt %0d..%0d", pan_lo, pan_hi, tilt_lo, tilt_hi);
    if (bad_count == 0) begin
      $display("pan_tilt_stepper_jog_core_tb passed");
    end else begin
      $display("pan_tilt_stepper_jog_core_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/ptsj_pkg.sv
design/ptsj_cfg.sv
design/ptsj_ctrl.sv
design/pan_tilt_stepper_jog_core.sv
test/pan_tilt_stepper_jog_core_tb.sv
